// ===== hw/rtl/utv_pkg.sv =====
package utv_pkg;

   localparam int unsigned LIMIT_PARAM_W = 24;
   localparam logic [LIMIT_PARAM_W-1:0] LENGTH_LIMIT_MAX_DEFAULT = 24'd65535;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam int unsigned LENGTH_W = 16;
   localparam logic [LENGTH_W-1:0] LENGTH_CAP = 16'hFFFF;

   localparam int unsigned COUNT_W = 17;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 17'h1FFFF;

   localparam int unsigned CP_W = 21;
   localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
   localparam logic [CP_W-1:0] MIN_TWO = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR = 21'h010000;

   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] DEL_BYTE = 8'h7F;

   // byte kinds
   localparam logic [2:0] KIND_ASCII = 3'd0;
   localparam logic [2:0] KIND_CONT = 3'd1;
   localparam logic [2:0] KIND_LEAD2 = 3'd2;
   localparam logic [2:0] KIND_LEAD3 = 3'd3;
   localparam logic [2:0] KIND_LEAD4 = 3'd4;
   localparam logic [2:0] KIND_BAD = 3'd5;

   // sequence classes
   localparam logic [1:0] SEQ_NONE = 2'd0;
   localparam logic [1:0] SEQ_TWO = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG = 2'd1;
   localparam logic [1:0] ERR_MALFORMED = 2'd2;
   localparam logic [1:0] ERR_CONTROL = 2'd3;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic REG_BYTE_LIMIT = 1'b0;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] payload;
      logic       ctrl;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic       text_ok;
      logic [1:0] error_code;
   } verdict_type;

endpackage

// ===== hw/rtl/utv_fifo.sv =====
module utv_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = utv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/utv_front.sv =====
module utv_front (
   input  logic                    data_valid,
   input  logic [7:0]              data_byte,
   input  logic                    last_byte,
   output logic                    item_push,
   output utv_pkg::byte_item_type  item
);

   assign item_push = data_valid;

   always_comb begin
      item.ctrl = (data_byte < utv_pkg::CTRL_LIMIT) || (data_byte == utv_pkg::DEL_BYTE);
      item.last = last_byte;
      item.payload = data_byte[5:0];
      if (!data_byte[7]) begin
         item.kind = utv_pkg::KIND_ASCII;
      end else if (data_byte[7:6] == 2'b10) begin
         item.kind = utv_pkg::KIND_CONT;
      end else if (data_byte[7:5] == 3'b110) begin
         item.kind = utv_pkg::KIND_LEAD2;
         item.payload = {1'b0, data_byte[4:0]};
      end else if (data_byte[7:4] == 4'b1110) begin
         item.kind = utv_pkg::KIND_LEAD3;
         item.payload = {2'b0, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
         item.kind = utv_pkg::KIND_LEAD4;
         item.payload = {3'b0, data_byte[2:0]};
      end else begin
         item.kind = utv_pkg::KIND_BAD;
      end
   end

endmodule

// ===== hw/rtl/utv_back.sv =====
module utv_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  utv_pkg::byte_item_type            item,
   input  logic [utv_pkg::LENGTH_W-1:0]      limit,
   input  logic                              verdict_full,
   output logic                              item_pop,
   output logic                              verdict_push,
   output utv_pkg::verdict_type              verdict
);

   logic [utv_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [1:0]                  pend_ff, pend_in;
   logic [utv_pkg::CP_W-1:0]    cp_ff, cp_in;
   logic [1:0]                  cls_ff, cls_in;
   logic                        bad_ff, bad_in;
   logic                        ctrl_ff, ctrl_in;
   logic [utv_pkg::CP_W-1:0]    cp_next;
   logic [utv_pkg::CP_W-1:0]    cp_min;
   logic                        advance;
   logic [1:0]                  code;

   assign advance = item_valid && !verdict_full;
   assign item_pop = advance;
   assign cp_next = {cp_ff[utv_pkg::CP_W-7:0], item.payload};

   always_comb begin
      case (cls_ff)
         utv_pkg::SEQ_TWO: cp_min = utv_pkg::MIN_TWO;
         utv_pkg::SEQ_THREE: cp_min = utv_pkg::MIN_THREE;
         default: cp_min = utv_pkg::MIN_FOUR;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      pend_in = pend_ff;
      cp_in = cp_ff;
      cls_in = cls_ff;
      bad_in = bad_ff;
      ctrl_in = ctrl_ff;
      code = utv_pkg::ERR_NONE;
      verdict_push = 1'b0;
      if (advance) begin
         if (count_ff != utv_pkg::COUNT_SAT) begin
            count_in = count_ff + 1'b1;
         end
         if (item.ctrl) begin
            ctrl_in = 1'b1;
         end
         if (!bad_ff) begin
            if (pend_ff == 2'd0) begin
               case (item.kind)
                  utv_pkg::KIND_ASCII: begin
                  end
                  utv_pkg::KIND_LEAD2: begin
                     pend_in = 2'd1;
                     cls_in = utv_pkg::SEQ_TWO;
                     cp_in = utv_pkg::CP_W'(item.payload);
                  end
                  utv_pkg::KIND_LEAD3: begin
                     pend_in = 2'd2;
                     cls_in = utv_pkg::SEQ_THREE;
                     cp_in = utv_pkg::CP_W'(item.payload);
                  end
                  utv_pkg::KIND_LEAD4: begin
                     pend_in = 2'd3;
                     cls_in = utv_pkg::SEQ_FOUR;
                     cp_in = utv_pkg::CP_W'(item.payload);
                  end
                  default: bad_in = 1'b1;
               endcase
            end else if (item.kind != utv_pkg::KIND_CONT) begin
               bad_in = 1'b1;
            end else begin
               pend_in = pend_ff - 1'b1;
               cp_in = cp_next;
               if (pend_ff == 2'd1) begin
                  // sequence complete: reject overlong, out of range and surrogates
                  if ((cp_next < cp_min) || (cp_next > utv_pkg::CP_MAX) ||
                      ((cp_next >= utv_pkg::SURR_LO) && (cp_next <= utv_pkg::SURR_HI))) begin
                     bad_in = 1'b1;
                  end
                  cp_in = '0;
                  cls_in = utv_pkg::SEQ_NONE;
               end
            end
         end
         if (item.last) begin
            verdict_push = 1'b1;
            if (count_in > {1'b0, limit}) begin
               code = utv_pkg::ERR_TOO_LONG;
            end else if (bad_in || (pend_in != 2'd0)) begin
               code = utv_pkg::ERR_MALFORMED;
            end else if (ctrl_in) begin
               code = utv_pkg::ERR_CONTROL;
            end
            // clear for the next text
            count_in = '0;
            pend_in = 2'd0;
            cp_in = '0;
            cls_in = utv_pkg::SEQ_NONE;
            bad_in = 1'b0;
            ctrl_in = 1'b0;
         end
      end
      verdict.error_code = code;
      verdict.text_ok = (code == utv_pkg::ERR_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff <= 2'd0;
         cp_ff <= '0;
         cls_ff <= utv_pkg::SEQ_NONE;
         bad_ff <= 1'b0;
         ctrl_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff <= pend_in;
         cp_ff <= cp_in;
         cls_ff <= cls_in;
         bad_ff <= bad_in;
         ctrl_ff <= ctrl_in;
      end
   end

endmodule

// ===== hw/rtl/utf8_text_validator_unit.sv =====
// UTF-8 text validator.
// Requests carry one byte of a text each (req_data_byte) with req_last_byte set
// on the final byte; a request is taken at a clock edge with req_push high and
// req_full low. Texts are never empty.
// One verdict comes out per text on the result side: rsp_text_ok and
// rsp_error_code (none, too long, malformed UTF-8, control byte, in that
// priority) are valid while rsp_empty is low and are taken with rsp_pop.
// Throughput is one byte per cycle while the result queue has room: a
// classifier feeds a short queue and the decode/verdict stage consumes one
// entry per cycle into the result queue. A final byte passes the byte queue,
// then its verdict is registered in the result queue and rsp_empty falls.
// If the receiver stalls, verdicts collect in the result queue; once it fills
// the decode stage holds, then the byte queue fills and req_full rises.
// The length limit is the smaller of the byte limit register (CSR at byte
// address 0) and LENGTH_LIMIT_MAX; write it only while no text is in flight.
// Synchronous reset empties both queues, clears the text state and sets the
// byte limit register to LENGTH_LIMIT_MAX capped at 0xFFFF.
module utf8_text_validator_unit #(
   parameter logic [utv_pkg::LIMIT_PARAM_W-1:0] LENGTH_LIMIT_MAX =
      utv_pkg::LENGTH_LIMIT_MAX_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = utv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_text_ok,
   output logic [1:0]                         rsp_error_code,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [utv_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [utv_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [utv_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam logic [utv_pkg::LENGTH_W-1:0] LIMIT_CAP =
      (LENGTH_LIMIT_MAX > utv_pkg::LIMIT_PARAM_W'(utv_pkg::LENGTH_CAP)) ?
      utv_pkg::LENGTH_CAP : LENGTH_LIMIT_MAX[utv_pkg::LENGTH_W-1:0];
   localparam int unsigned ITEM_W = $bits(utv_pkg::byte_item_type);
   localparam int unsigned VERDICT_W = $bits(utv_pkg::verdict_type);

   logic [utv_pkg::LENGTH_W-1:0] byte_limit_ff, byte_limit_in;
   logic [utv_pkg::LENGTH_W-1:0] limit;
   logic                         csr_write;

   utv_pkg::byte_item_type front_item, back_item;
   logic                   front_push;
   logic                   mid_empty, mid_pop;
   utv_pkg::verdict_type   verdict, rsp_verdict;
   logic                   verdict_push, verdict_full;
   logic [ITEM_W-1:0]      back_item_bits;
   logic [VERDICT_W-1:0]   rsp_verdict_bits;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite &&
                      (csr_paddr[utv_pkg::CSR_ADDR_W-1] == utv_pkg::REG_BYTE_LIMIT);
   assign csr_prdata = (csr_paddr[utv_pkg::CSR_ADDR_W-1] == utv_pkg::REG_BYTE_LIMIT) ?
                       utv_pkg::CSR_DATA_W'(byte_limit_ff) : '0;
   assign byte_limit_in = csr_write ? csr_pwdata[utv_pkg::LENGTH_W-1:0] : byte_limit_ff;
   assign limit = (byte_limit_ff < LIMIT_CAP) ? byte_limit_ff : LIMIT_CAP;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff <= LIMIT_CAP;
      end else begin
         byte_limit_ff <= byte_limit_in;
      end
   end

   utv_front u_front (
      .data_valid (req_push),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .item_push  (front_push),
      .item       (front_item)
   );

   utv_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_byte_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (mid_pop),
      .pop_data  (back_item_bits),
      .empty     (mid_empty)
   );

   assign back_item = utv_pkg::byte_item_type'(back_item_bits);

   utv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (!mid_empty),
      .item         (back_item),
      .limit        (limit),
      .verdict_full (verdict_full),
      .item_pop     (mid_pop),
      .verdict_push (verdict_push),
      .verdict      (verdict)
   );

   utv_fifo #(
      .WIDTH (VERDICT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_verdict_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (verdict_push),
      .push_data (verdict),
      .full      (verdict_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_verdict_bits),
      .empty     (rsp_empty)
   );

   assign rsp_verdict = utv_pkg::verdict_type'(rsp_verdict_bits);
   assign rsp_text_ok = rsp_verdict.text_ok;
   assign rsp_error_code = rsp_verdict.error_code;

endmodule
